// ===== src/lz77_window_decompressor_core_macros.svh =====
// Assertion macros used by the decompressor checker.
`ifndef LZ77_WINDOW_DECOMPRESSOR_CORE_MACROS_SVH
`define LZ77_WINDOW_DECOMPRESSOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LZWD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LZWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/lzwd_pkg.sv =====
// Shared types and constants of the LZ77 window decompressor.
`default_nettype none
package lzwd_pkg;

	localparam int WINDOW_DEPTH_DEF = 4096;
	localparam int QUEUE_DEPTH_DEF  = 4;
	localparam int BYTE_W = 8;
	localparam int POS_W  = 12;
	localparam int LEN_W  = 4;
	localparam int RUN_W  = LEN_W + 1;

	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              run_last;
		logic              stream_end;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_LIT,
		CMD_COPY,
		CMD_END
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [BYTE_W-1:0] lit;
		logic [POS_W-1:0]  pos;
		logic [LEN_W-1:0]  len;
	} cmd_t;

endpackage
`default_nettype wire

// ===== src/lzwd_stream_if.sv =====
// Valid/ready stream channel with a generic payload.
`default_nettype none
interface lzwd_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/lzwd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lzwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = lzwd_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== src/lzwd_cmd_fifo.sv =====
// Short command queue between the parser and the window engine.
`default_nettype none
module lzwd_cmd_fifo #(
	parameter int DEPTH = lzwd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lzwd_pkg::cmd_t wr_cmd,
	input  logic          pop,
	output lzwd_pkg::cmd_t rd_cmd,
	output logic          full,
	output logic          empty
);
	import lzwd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_cmd  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/lzwd_front.sv =====
// Stream parser: tracks tag flags and turns input bytes into window commands.
`default_nettype none
module lzwd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  lzwd_pkg::in_item_t in_item,
	input  logic              hold,
	output logic              ready,
	output logic              push,
	output lzwd_pkg::cmd_t    cmd
);
	import lzwd_pkg::*;

	typedef enum logic [1:0] {
		PH_TAG,
		PH_ITEM,
		PH_HIGH
	} phase_t;

	phase_t              phase_q;
	logic [BYTE_W-1:0]   flags_q;
	logic [2:0]          flag_pos_q;
	logic [BYTE_W-1:0]   low_q;
	logic                accept;
	logic [2*BYTE_W-1:0] word;
	logic                end_word;

	assign ready    = !hold;
	assign accept   = in_valid && !hold;
	assign word     = {in_item.in_byte, low_q};
	assign end_word = (word[2*BYTE_W-1:LEN_W] == '0);

	always_comb begin
		push     = 1'b0;
		cmd.kind = CMD_LIT;
		cmd.lit  = in_item.in_byte;
		cmd.pos  = word[2*BYTE_W-1:LEN_W];
		cmd.len  = word[LEN_W-1:0];
		if (accept) begin
			case (phase_q)
				PH_ITEM: begin
					push = !flags_q[flag_pos_q];
				end
				PH_HIGH: begin
					push     = 1'b1;
					cmd.kind = end_word ? CMD_END : CMD_COPY;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TAG;
			flags_q    <= '0;
			flag_pos_q <= '0;
			low_q      <= '0;
		end else if (accept) begin
			case (phase_q)
				PH_ITEM: begin
					if (!flags_q[flag_pos_q]) begin
						flag_pos_q <= flag_pos_q + 1'b1;
						phase_q    <= (flag_pos_q == 3'd7) ? PH_TAG : PH_ITEM;
					end else begin
						low_q   <= in_item.in_byte;
						phase_q <= PH_HIGH;
					end
				end
				PH_HIGH: begin
					if (end_word) begin
						flag_pos_q <= '0;
						phase_q    <= PH_TAG;
					end else begin
						flag_pos_q <= flag_pos_q + 1'b1;
						phase_q    <= (flag_pos_q == 3'd7) ? PH_TAG : PH_ITEM;
					end
				end
				default: begin
					flags_q    <= in_item.in_byte;
					flag_pos_q <= '0;
					phase_q    <= PH_ITEM;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== src/lzwd_back.sv =====
// Window engine: clears the history, executes literal, copy and end commands.
`default_nettype none
module lzwd_back #(
	parameter int WINDOW_DEPTH = lzwd_pkg::WINDOW_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  lzwd_pkg::cmd_t     head,
	output logic               pop,
	output logic               clearing,
	output logic               out_valid,
	input  logic               out_ready,
	output lzwd_pkg::out_item_t out_item
);
	import lzwd_pkg::*;

	localparam int AW = $clog2(WINDOW_DEPTH);

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_COPY
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     clr_addr_q;
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [RUN_W-1:0]  left_q;
	logic              fwd_q;
	logic [BYTE_W-1:0] fwd_byte_q;
	logic              out_valid_q;
	out_item_t         out_item_q;

	logic              slot_free;
	logic [AW-1:0]     rd_next;
	logic [BYTE_W-1:0] copy_byte;
	logic              emit;
	out_item_t         emit_item;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;

	assign slot_free = !out_valid_q || out_ready;
	assign rd_next   = rd_ptr_q + 1'b1;
	assign copy_byte = fwd_q ? fwd_byte_q : ram_rdata;
	assign clearing  = (state_q == BK_CLEAR);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	lzwd_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(WINDOW_DEPTH)
	) u_window (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		pop                  = 1'b0;
		ram_we               = 1'b0;
		ram_waddr            = wr_ptr_q;
		ram_wdata            = copy_byte;
		ram_re               = 1'b0;
		ram_raddr            = rd_next;
		emit                 = 1'b0;
		emit_item.out_byte   = copy_byte;
		emit_item.run_last   = (left_q == '0);
		emit_item.stream_end = 1'b0;
		case (state_q)
			BK_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
			end
			BK_IDLE: begin
				if (!empty) begin
					case (head.kind)
						CMD_LIT: begin
							if (slot_free) begin
								pop                = 1'b1;
								ram_we             = 1'b1;
								ram_wdata          = head.lit;
								emit               = 1'b1;
								emit_item.out_byte = head.lit;
								emit_item.run_last = 1'b1;
							end
						end
						CMD_END: begin
							if (slot_free) begin
								pop                  = 1'b1;
								emit                 = 1'b1;
								emit_item.out_byte   = '0;
								emit_item.run_last   = 1'b1;
								emit_item.stream_end = 1'b1;
							end
						end
						CMD_COPY: begin
							pop       = 1'b1;
							ram_re    = 1'b1;
							ram_raddr = AW'(head.pos);
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			BK_COPY: begin
				if (slot_free) begin
					ram_we = 1'b1;
					emit   = 1'b1;
					ram_re = (left_q != '0);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_addr_q  <= '0;
			wr_ptr_q    <= AW'(1);
			rd_ptr_q    <= '0;
			left_q      <= '0;
			fwd_q       <= 1'b0;
			fwd_byte_q  <= '0;
			out_valid_q <= 1'b0;
			out_item_q  <= '0;
		end else begin
			case (state_q)
				BK_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == '1) begin
						state_q <= BK_IDLE;
					end
				end
				BK_IDLE: begin
					if (!empty) begin
						case (head.kind)
							CMD_LIT: begin
								if (slot_free) begin
									wr_ptr_q <= wr_ptr_q + 1'b1;
								end
							end
							CMD_END: begin
								if (slot_free) begin
									wr_ptr_q <= AW'(1);
								end
							end
							CMD_COPY: begin
								rd_ptr_q <= AW'(head.pos);
								left_q   <= {1'b0, head.len} + RUN_W'(1);
								fwd_q    <= 1'b0;
								state_q  <= BK_COPY;
							end
							default: ;
						endcase
					end
				end
				BK_COPY: begin
					if (slot_free) begin
						wr_ptr_q   <= wr_ptr_q + 1'b1;
						rd_ptr_q   <= rd_next;
						left_q     <= left_q - 1'b1;
						// next read hits the byte written this cycle: bypass the RAM
						fwd_q      <= (rd_next == wr_ptr_q);
						fwd_byte_q <= copy_byte;
						if (left_q == '0) begin
							state_q <= BK_IDLE;
						end
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase

			if (emit) begin
				out_valid_q <= 1'b1;
				out_item_q  <= emit_item;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/lz77_window_decompressor_core.sv =====
// Top level of the LZ77 decompressor with a 4096-byte history window.
// Order: a literal at the queue head is loaded into the output register once that register is free;
// a copy first reads the window RAM, then sends 1 byte per cycle to the output register while it is free.
// Throughput: the parser takes 1 byte per cycle while the window is not being cleared and the queue
// has room; the engine, limited by its single output register, delivers at most 1 result per cycle.
// Reset: asynchronous and active low; afterwards the engine zeroes the window, one entry a cycle,
// through all WINDOW_DEPTH entries, and the input stays not ready until that pass ends.
`default_nettype none
module lz77_window_decompressor_core #(
	parameter int WINDOW_DEPTH = lzwd_pkg::WINDOW_DEPTH_DEF,
	parameter int QUEUE_DEPTH  = lzwd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	lzwd_stream_if.sink          compressed,
	lzwd_stream_if.source        decompressed
);
	import lzwd_pkg::*;

	// Front side: parser state and the commands it produces.
	logic      front_hold;
	logic      cmd_push;
	cmd_t      cmd_in;

	// Queue status and head seen by the window engine.
	logic      queue_full;
	logic      queue_empty;
	logic      cmd_pop;
	cmd_t      cmd_head;

	// Engine status and result register.
	logic      clearing;
	out_item_t result;

	// Hold the input off while the window is being cleared or the queue has no room.
	assign front_hold = clearing || queue_full;

	// Parser: every accepted byte updates the parser state; literals, copies and stream ends
	// become one command each, tags and low word bytes produce nothing.
	lzwd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(compressed.valid),
		.in_item (compressed.data),
		.hold    (front_hold),
		.ready   (compressed.ready),
		.push    (cmd_push),
		.cmd     (cmd_in)
	);

	// Decouple the parser from the engine so either side can stall on its own.
	lzwd_cmd_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.wr_cmd(cmd_in),
		.pop   (cmd_pop),
		.rd_cmd(cmd_head),
		.full  (queue_full),
		.empty (queue_empty)
	);

	// Engine: owns the window RAM and the write pointer and emits one result transaction per cycle at most;
	// it starts a copy without waiting, and otherwise advances only when the output register can take it.
	lzwd_back #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (queue_empty),
		.head     (cmd_head),
		.pop      (cmd_pop),
		.clearing (clearing),
		.out_valid(decompressed.valid),
		.out_ready(decompressed.ready),
		.out_item (result)
	);

	assign decompressed.data = result;
endmodule
`default_nettype wire

// ===== src/lzwd_checker.sv =====
// Port-level checks of the decompressor, bound to the top level.
`default_nettype none
`include "lz77_window_decompressor_core_macros.svh"
module lzwd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       run_last,
	input logic       stream_end
);
	`LZWD_ASSERT_IMPL(a_reset_quiet, clk, arst_n, !$past(arst_n), !out_valid && !in_ready, "activity right after reset")
	`LZWD_ASSERT_IMPL(a_end_shape, clk, arst_n, out_valid && stream_end, run_last && (out_byte == 8'd0), "malformed end transaction")
	`LZWD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped under stall")
	`LZWD_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_byte) && $stable(run_last) && $stable(stream_end), "result changed under stall")
endmodule

bind lz77_window_decompressor_core lzwd_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (compressed.ready),
	.out_valid (decompressed.valid),
	.out_ready (decompressed.ready),
	.out_byte  (decompressed.data.out_byte),
	.run_last  (decompressed.data.run_last),
	.stream_end(decompressed.data.stream_end)
);
`default_nettype wire
